@@ hw/rtl/mrpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mrpt_pkg;

	localparam int WIDTH = 64;
	localparam int CAND_W = WIDTH - 1;
	localparam int IDX_W = $clog2(WIDTH);
	localparam int NUM_BASES = 7;
	localparam int BIDX_W = 3;

	typedef logic [WIDTH-1:0] data_t;

	typedef enum logic [1:0] {
		MOP_RED,
		MOP_ACC,
		MOP_SQ,
		MOP_XX
	} mul_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_SMALL,
		ST_STRIP,
		ST_BRED,
		ST_BRED_W,
		ST_BCHK,
		ST_POW,
		ST_ACC_W,
		ST_POW_SQ,
		ST_SQ_W,
		ST_CHK,
		ST_LOOP,
		ST_LOOP_W,
		ST_LCHK,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic strip;
		logic mul_start;
		mul_op_t mul_op;
		logic [BIDX_W-1:0] base_idx;
		logic pow_init;
		logic e_shift;
		logic t_init;
		logic t_inc;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic n_le1;
		logic n_small_prime;
		logic n_div235;
		logic d_even;
		logic e_zero;
		logic e_odd;
		logic sq_zero;
		logic acc_one;
		logic acc_nm1;
		logic t_lt_s;
	} status_t;

	function automatic data_t base_value(input logic [BIDX_W-1:0] idx);
		data_t v;
		v = '0;
		unique case (idx)
			3'd0: v = data_t'(2);
			3'd1: v = data_t'(325);
			3'd2: v = data_t'(9375);
			3'd3: v = data_t'(28178);
			3'd4: v = data_t'(450775);
			3'd5: v = data_t'(9780504);
			3'd6: v = data_t'(1795265022);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mrpt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mrpt_dp import mrpt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [CAND_W-1:0] candidate,
	input wire cmd_t cmd,
	output status_t status
);

	data_t n_q, nm1_q, d_q, e_q, acc_q, sq_q;
	logic [CAND_W-1:0] sh_q;
	logic [1:0] m3_q;
	logic [2:0] m5_q;
	logic [IDX_W-1:0] s_q, t_q;

	// Shift-and-add modular multiplier, one bit of the multiplier per cycle.
	data_t ma_q, mb_q, mr_q;
	logic [IDX_W-1:0] mi_q;
	logic mbusy_q;
	mul_op_t mop_q;
	data_t r_dbl, r_dbl_red, r_add, r_next;
	data_t op_a, op_b;
	logic mdone;

	logic [2:0] v3, v3n;
	logic [3:0] v5, v5n;

	always_comb begin
		r_dbl = {mr_q[WIDTH-2:0], 1'b0};
		r_dbl_red = (r_dbl >= n_q) ? r_dbl - n_q : r_dbl;
		r_add = mb_q[mi_q] ? r_dbl_red + ma_q : r_dbl_red;
		r_next = (r_add >= n_q) ? r_add - n_q : r_add;
		mdone = mbusy_q && (mi_q == '0);
	end

	always_comb begin
		op_a = acc_q;
		op_b = sq_q;
		unique case (cmd.mul_op)
			MOP_RED: begin
				op_a = data_t'(1);
				op_b = base_value(cmd.base_idx);
			end
			MOP_ACC: begin
				op_a = acc_q;
				op_b = sq_q;
			end
			MOP_SQ: begin
				op_a = sq_q;
				op_b = sq_q;
			end
			MOP_XX: begin
				op_a = acc_q;
				op_b = acc_q;
			end
			default: begin
				op_a = acc_q;
				op_b = sq_q;
			end
		endcase
	end

	always_comb begin
		v3 = {m3_q, sh_q[CAND_W-1]};
		v3n = (v3 >= 3'd3) ? v3 - 3'd3 : v3;
		v5 = {m5_q, sh_q[CAND_W-1]};
		v5n = (v5 >= 4'd5) ? v5 - 4'd5 : v5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mi_q <= '0;
			mop_q <= MOP_RED;
		end else begin
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
				mi_q <= IDX_W'(WIDTH - 1);
				mop_q <= cmd.mul_op;
			end else if (mbusy_q) begin
				mi_q <= mi_q - 1'b1;
				if (mi_q == '0) begin
					mbusy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_q <= op_a;
			mb_q <= op_b;
			mr_q <= '0;
		end else if (mbusy_q) begin
			mr_q <= r_next;
		end

		if (cmd.load) begin
			n_q <= {1'b0, candidate};
			nm1_q <= {1'b0, candidate} - 1'b1;
			d_q <= {1'b0, candidate} - 1'b1;
			sh_q <= candidate;
			m3_q <= '0;
			m5_q <= '0;
			s_q <= '0;
		end
		if (cmd.prep) begin
			sh_q <= {sh_q[CAND_W-2:0], 1'b0};
			m3_q <= v3n[1:0];
			m5_q <= v5n[2:0];
		end
		if (cmd.strip) begin
			d_q <= {1'b0, d_q[WIDTH-1:1]};
			s_q <= s_q + 1'b1;
		end
		if (cmd.pow_init) begin
			acc_q <= data_t'(1);
			e_q <= d_q;
		end
		if (cmd.e_shift) begin
			e_q <= {1'b0, e_q[WIDTH-1:1]};
		end
		if (cmd.t_init) begin
			t_q <= IDX_W'(1);
		end
		if (cmd.t_inc) begin
			t_q <= t_q + 1'b1;
		end
		if (mdone) begin
			if (mop_q == MOP_RED || mop_q == MOP_SQ) begin
				sq_q <= r_next;
			end else begin
				acc_q <= r_next;
			end
		end
	end

	always_comb begin
		status.mul_done = mdone;
		status.n_le1 = (n_q <= data_t'(1));
		status.n_small_prime = (n_q == data_t'(2)) || (n_q == data_t'(3))
			|| (n_q == data_t'(5));
		status.n_div235 = !n_q[0] || (m3_q == '0) || (m5_q == '0);
		status.d_even = !d_q[0];
		status.e_zero = (e_q == '0);
		status.e_odd = e_q[0];
		status.sq_zero = (sq_q == '0);
		status.acc_one = (acc_q == data_t'(1));
		status.acc_nm1 = (acc_q == nm1_q);
		status.t_lt_s = (t_q < s_q);
	end

endmodule
`default_nettype wire

@@ hw/rtl/mrpt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mrpt_ctrl import mrpt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	output logic prime_flag,
	input wire status_t status,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [IDX_W-1:0] pc_q, pc_d;
	logic [BIDX_W-1:0] bidx_q, bidx_d;
	logic verd_q, verd_d;
	logic oval_q, oval_d;
	logic flag_q, flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			bidx_q <= '0;
			verd_q <= 1'b0;
			oval_q <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q <= pc_d;
			bidx_q <= bidx_d;
			verd_q <= verd_d;
			oval_q <= oval_d;
			flag_q <= flag_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pc_d = pc_q;
		bidx_d = bidx_q;
		verd_d = verd_q;
		flag_d = flag_q;
		oval_d = oval_q && out_stall;
		cmd = '0;
		cmd.base_idx = bidx_q;
		cmd.mul_op = MOP_RED;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pc_d = IDX_W'(CAND_W - 1);
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (pc_q == '0) begin
					state_d = ST_SMALL;
				end else begin
					pc_d = pc_q - 1'b1;
				end
			end
			ST_SMALL: begin
				priority if (status.n_le1) begin
					verd_d = 1'b0;
					state_d = ST_DONE;
				end else if (status.n_small_prime) begin
					verd_d = 1'b1;
					state_d = ST_DONE;
				end else if (status.n_div235) begin
					verd_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					state_d = ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (status.d_even) begin
					cmd.strip = 1'b1;
				end else begin
					bidx_d = '0;
					state_d = ST_BRED;
				end
			end
			ST_BRED: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op = MOP_RED;
				state_d = ST_BRED_W;
			end
			ST_BRED_W: begin
				if (status.mul_done) begin
					state_d = ST_BCHK;
				end
			end
			ST_BCHK: begin
				// A base that is a multiple of the candidate proves nothing.
				if (status.sq_zero) begin
					state_d = ST_NEXT;
				end else begin
					cmd.pow_init = 1'b1;
					state_d = ST_POW;
				end
			end
			ST_POW: begin
				priority if (status.e_zero) begin
					state_d = ST_CHK;
				end else if (status.e_odd) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op = MOP_ACC;
					state_d = ST_ACC_W;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_op = MOP_SQ;
					state_d = ST_SQ_W;
				end
			end
			ST_ACC_W: begin
				if (status.mul_done) begin
					state_d = ST_POW_SQ;
				end
			end
			ST_POW_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op = MOP_SQ;
				state_d = ST_SQ_W;
			end
			ST_SQ_W: begin
				if (status.mul_done) begin
					cmd.e_shift = 1'b1;
					state_d = ST_POW;
				end
			end
			ST_CHK: begin
				if (status.acc_one || status.acc_nm1) begin
					state_d = ST_NEXT;
				end else begin
					cmd.t_init = 1'b1;
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (status.t_lt_s) begin
					cmd.mul_start = 1'b1;
					cmd.mul_op = MOP_XX;
					state_d = ST_LOOP_W;
				end else begin
					verd_d = 1'b0;
					state_d = ST_DONE;
				end
			end
			ST_LOOP_W: begin
				if (status.mul_done) begin
					state_d = ST_LCHK;
				end
			end
			ST_LCHK: begin
				if (status.acc_nm1) begin
					state_d = ST_NEXT;
				end else begin
					cmd.t_inc = 1'b1;
					state_d = ST_LOOP;
				end
			end
			ST_NEXT: begin
				if (bidx_q == BIDX_W'(NUM_BASES - 1)) begin
					verd_d = 1'b1;
					state_d = ST_DONE;
				end else begin
					bidx_d = bidx_q + 1'b1;
					state_d = ST_BRED;
				end
			end
			ST_DONE: begin
				// Wait until the output register is free.
				if (!oval_q || !out_stall) begin
					oval_d = 1'b1;
					flag_d = verd_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = oval_q;
	assign prime_flag = flag_q;

endmodule
`default_nettype wire

@@ hw/rtl/miller_rabin_prime_test_64_core.sv @@
// Deterministic Miller-Rabin primality test for 63-bit candidates.
// Input channel: in_valid / in_stall with candidate. An item is taken on a
// rising edge with in_valid high and in_stall low. Output channel: out_valid /
// out_stall with prime_flag, one result per item, in order.
// One item is worked on at a time; in_stall is high from acceptance until the
// verdict is written to the output register, so a new item may be taken while
// the previous result still waits there.
// Steps: the residues mod 3 and 5 are found first, then the trailing zeros of
// n-1 are stripped, then for each of seven bases come one modular reduction
// and up to about two multiplications per bit of d plus up to s-1 squarings,
// all on the single shift-and-add modular multiplier. Candidates up to 5 and
// those divisible by 2, 3 or 5 finish without the bases; large primes take
// the longest.
// Reset clears the controller and drops out_valid. While out_stall is high the
// result holds; a finished verdict then waits in the controller until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none
module miller_rabin_prime_test_64_core import mrpt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [CAND_W-1:0] candidate,
	output logic out_valid,
	input wire logic out_stall,
	output logic prime_flag
);

	cmd_t cmd;
	status_t status;

	mrpt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.prime_flag(prime_flag),
		.status(status),
		.cmd(cmd)
	);

	mrpt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.candidate(candidate),
		.cmd(cmd),
		.status(status)
	);

endmodule
`default_nettype wire

@@ hw/rtl/mrpt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mrpt_checker import mrpt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [CAND_W-1:0] candidate,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic prime_flag
);

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_flag_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(prime_flag))
		else $error("prime_flag changed while stalled");

	a_in_item_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(candidate))
		else $error("input item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an item was taken");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 !$rose(out_valid))
		else $error("result appeared too soon after an item was taken");

endmodule

bind miller_rabin_prime_test_64_core mrpt_checker u_mrpt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.candidate(candidate),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.prime_flag(prime_flag)
);
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import mrpt_pkg::CAND_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [CAND_W-1:0] candidate = '0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic prime_flag;

	bit verdict_q[$];
	logic [CAND_W-1:0] cand_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int primes_seen = 0;
	int items_sent = 0;
	bit idle_on = 1'b1;
	int hold_cycles = 0;

	miller_rabin_prime_test_64_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.candidate(candidate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.prime_flag(prime_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] n);
		logic [127:0] p;
		p = a * b;
		p = p % {64'd0, n};
		return p[63:0];
	endfunction

	function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
			input logic [63:0] n);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1 % n;
		sq = b;
		while (e != 0) begin
			if (e[0])
				acc = mulmod(acc, sq, n);
			sq = mulmod(sq, sq, n);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit prime_verdict(input logic [CAND_W-1:0] c);
		logic [63:0] witnesses[7];
		logic [63:0] n;
		logic [63:0] nm1;
		logic [63:0] d;
		logic [63:0] a;
		logic [63:0] x;
		int s;
		bit passed;
		witnesses = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
			64'd1795265022};
		n = {1'b0, c};
		if (n <= 1)
			return 1'b0;
		if (n == 2 || n == 3 || n == 5)
			return 1'b1;
		if (n % 2 == 0 || n % 3 == 0 || n % 5 == 0)
			return 1'b0;
		nm1 = n - 1;
		d = nm1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		foreach (witnesses[i]) begin
			a = witnesses[i] % n;
			// A witness that the candidate divides says nothing and is skipped.
			if (a == 0)
				continue;
			x = powmod(a, d, n);
			if (x == 1 || x == nm1)
				continue;
			passed = 1'b0;
			for (int t = 1; t < s; t++) begin
				x = mulmod(x, x, n);
				if (x == nm1) begin
					passed = 1'b1;
					break;
				end
			end
			if (!passed)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send_candidate(input logic [CAND_W-1:0] c);
		int gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		candidate <= c;
		do @(posedge clk); while (in_stall);
		verdict_q.push_back(prime_verdict(c));
		cand_q.push_back(c);
		items_sent++;
	endtask

	// Output side: optional long hold, then, while idle_on is set, a random stall before each item.
	initial begin
		int n;
		forever begin
			if (hold_cycles > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			n = idle_on ? $urandom_range(0, 19) : 0;
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result prime_flag=%0b", prime_flag);
			end else begin
				if (prime_flag !== verdict_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("candidate %0d: expected prime_flag=%0b, got %0b",
							cand_q[0], verdict_q[0], prime_flag);
				end
				if (verdict_q[0])
					primes_seen++;
				void'(verdict_q.pop_front());
				void'(cand_q.pop_front());
			end
		end
	end

	task automatic test_directed;
		logic [CAND_W-1:0] list[$];
		list = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd6, 63'd7, 63'd9, 63'd25,
			63'd13, 63'd19, 63'd73, 63'd193, 63'd325, 63'd25326001, 63'd3215031751,
			63'd3825123056546413051, 63'd2305843009213693951,
			63'd9223372036854775783, {CAND_W{1'b1}}, 63'h4000000000000000,
			63'd1795265022, 63'd897632511};
		foreach (list[i])
			send_candidate(list[i]);
	endtask

	// The output stays stalled while the input side keeps offering cheap items,
	// so the block fills up and has to stall its input.
	task automatic test_backpressure;
		hold_cycles = 3000;
		repeat (6)
			send_candidate(63'($urandom_range(1, 100000)) * 2);
	endtask

	task automatic test_random;
		logic [CAND_W-1:0] c;
		int large_left;
		large_left = 6;
		for (int i = 0; i < 110; i++) begin
			idle_on = (i < 40 || i >= 70);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					case ($urandom_range(0, 2))
						0: c = 63'($urandom_range(1, 1000000)) * 2;
						1: c = 63'($urandom_range(1, 1000000)) * 3;
						default: c = 63'($urandom_range(1, 1000000)) * 5;
					endcase
				end
				4, 5, 6, 7: c = 63'($urandom_range(0, 4095));
				8: c = 63'($urandom_range(0, 24'hffffff)) | 63'd1;
				default: begin
					if (large_left > 0) begin
						c = 63'({$urandom, $urandom});
						large_left--;
					end else begin
						c = 63'($urandom_range(0, 1023));
					end
				end
			endcase
			send_candidate(c);
		end
		idle_on = 1'b1;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random();
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d verdicts (%0d prime) from %0d candidates, including edge values,",
			results_seen, primes_seen, items_sent);
		$display("known pseudoprimes, large primes, random sizes and a long output stall.");
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#600_000_000;
		$display("Timed out with %0d verdicts outstanding.", verdict_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_dp.sv
hw/rtl/mrpt_ctrl.sv
hw/rtl/miller_rabin_prime_test_64_core.sv
hw/rtl/mrpt_checker.sv
test/tb.sv
